>>> rtl/core/bitmap_page_allocator_assert.svh
// ----------------------------------------------------------------------------
// bitmap page allocator assertion macros
// concurrent checks sampled on clock, disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BPA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// widths, codes and types shared by the bitmap page allocator files
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int unsigned ADDR_W            = 64;
   localparam int unsigned STATUS_W          = 3;
   localparam int unsigned TOTAL_W           = 13;
   localparam int unsigned SHIFT_W           = 5;
   localparam int unsigned WORD_BITS         = 64;
   localparam int unsigned BIT_IDX_W         = 6;
   localparam int unsigned PAGE_IDX_W        = 13;
   localparam int unsigned CSR_IDX_W         = 2;
   localparam int unsigned DEFAULT_MAX_PAGES = 4096;

   localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd3;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd30;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK           = 3'd0,
      STATUS_NO_PAGES     = 3'd1,
      STATUS_RANGE        = 3'd2,
      STATUS_MISALIGNED   = 3'd3,
      STATUS_ALREADY_FREE = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REGION_BASE = 2'd0,
      CSR_PAGE_TOTAL  = 2'd1,
      CSR_PAGE_SHIFT  = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SELECT,
      S_CHECK,
      S_READ,
      S_MODIFY,
      S_ADDR,
      S_OUT
   } state_type;

endpackage

>>> rtl/core/bpa_req_if.sv
// ----------------------------------------------------------------------------
// bpa_req_if
// command channel: allocate or free one page
// ----------------------------------------------------------------------------
interface bpa_req_if;
   logic                         valid;
   logic                         ready;
   logic                         command;
   logic [bpa_pkg::ADDR_W-1:0]   address;

   modport source (output valid, output command, output address, input ready);
   modport sink   (input valid, input command, input address, output ready);
endinterface

>>> rtl/core/bpa_rsp_if.sv
// ----------------------------------------------------------------------------
// bpa_rsp_if
// result channel: page address and status of one command
// ----------------------------------------------------------------------------
interface bpa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bpa_pkg::ADDR_W-1:0]   page_address;
   logic [bpa_pkg::STATUS_W-1:0] status;

   modport source (output valid, output page_address, output status, input ready);
   modport sink   (input valid, input page_address, input status, output ready);
endinterface

>>> rtl/core/bpa_csr_if.sv
// ----------------------------------------------------------------------------
// bpa_csr_if
// register write channel: index and write data
// ----------------------------------------------------------------------------
interface bpa_csr_if;
   logic                          valid;
   logic                          ready;
   logic [bpa_pkg::CSR_IDX_W-1:0] index;
   logic [bpa_pkg::ADDR_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Page allocator with one used bit per page, kept in a 64-bit word memory.
// req_ch takes allocate/free transactions, rsp_ch returns one transaction each
// (page address and status), csr_ch writes region_base, page_total and
// page_shift and is always ready. One command is in flight at a time.
// A summary flop per word marks words with all bits set; allocate picks the
// first word not full below the page count, then read-modify-writes it.
// An allocate steps through S_SELECT, S_READ, S_MODIFY, S_ADDR and S_OUT, a
// free through S_SELECT, S_CHECK, S_READ, S_MODIFY and S_OUT. A bad free
// address goes to S_OUT from S_CHECK, an allocate whose word has no free page
// from S_MODIFY, and one that finds every word full from S_SELECT.
// The result is registered; a new command is taken while it waits, and a
// stalled rsp_ch holds the next result in its finishing state.
// Reset clears the summary flops and the control and region registers, then
// sweeps the memory to zero, one word a cycle over ceil(MAX_PAGES/64) words;
// req_ch is not ready during the sweep while csr_ch writes are still taken.
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_assert.svh"

module bitmap_page_allocator #(
   parameter int unsigned MAX_PAGES = bpa_pkg::DEFAULT_MAX_PAGES
) (
   input  logic      clock,
   input  logic      reset,
   bpa_req_if.sink   req_ch,
   bpa_rsp_if.source rsp_ch,
   bpa_csr_if.sink   csr_ch
);
   import bpa_pkg::*;

   localparam int unsigned MAP_WORDS  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned WORD_IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(MAP_WORDS - 1);

   // control state
   state_type               state_ff, state_in;
   logic [WORD_IDX_W-1:0]   clr_idx_ff, clr_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [MAP_WORDS-1:0]    full_ff, full_in;
   logic [ADDR_W-1:0]       region_base_ff, region_base_in;
   logic [TOTAL_W-1:0]      page_total_ff, page_total_in;
   logic [SHIFT_W-1:0]      page_shift_ff, page_shift_in;

   // payload
   cmd_type                 cmd_ff, cmd_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic                    below_ff, below_in;
   logic [WORD_IDX_W-1:0]   word_ff, word_in;
   logic [PAGE_IDX_W-1:0]   page_ff, page_in;
   logic [ADDR_W-1:0]       res_addr_ff, res_addr_in;
   status_type              res_status_ff, res_status_in;
   logic [ADDR_W-1:0]       rsp_addr_ff, rsp_addr_in;
   status_type              rsp_status_ff, rsp_status_in;

   // bitmap memory
   logic [WORD_BITS-1:0]    used_mem [MAP_WORDS];
   logic [WORD_BITS-1:0]    rd_data_ff;
   logic                    mem_we;
   logic [WORD_IDX_W-1:0]   mem_waddr;
   logic [WORD_BITS-1:0]    mem_wdata;

   // helpers
   logic [TOTAL_W-1:0]      eff_total;
   logic [TOTAL_W:0]        total_round;
   logic [TOTAL_W-BIT_IDX_W:0] word_limit;
   logic                    sel_found;
   logic [WORD_IDX_W-1:0]   sel_word;
   logic [ADDR_W-1:0]       span;
   logic [ADDR_W-1:0]       low_mask;
   logic [PAGE_IDX_W-1:0]   page_of;
   logic [TOTAL_W-1:0]      first_page;
   logic [TOTAL_W-1:0]      remaining;
   logic [WORD_BITS-1:0]    valid_mask;
   logic [WORD_BITS-1:0]    avail;
   logic [BIT_IDX_W-1:0]    lead_idx;
   logic [WORD_BITS-1:0]    free_bit;
   logic [SHIFT_W-1:0]      shift_wr;
   logic                    out_free;

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.page_address = rsp_addr_ff;
   assign rsp_ch.status       = rsp_status_ff;

   assign eff_total   = (32'(page_total_ff) > 32'(MAX_PAGES)) ? TOTAL_W'(MAX_PAGES)
                                                              : page_total_ff;
   // number of words holding at least one page below the count
   assign total_round = {1'b0, eff_total} + (TOTAL_W + 1)'(WORD_BITS - 1);
   assign word_limit  = total_round[TOTAL_W:BIT_IDX_W];

   // first word that is not full
   always_comb begin
      sel_found = 1'b0;
      sel_word  = '0;
      for (int w = int'(MAP_WORDS) - 1; w >= 0; w--) begin
         if (!full_ff[w] && (w < int'(word_limit))) begin
            sel_found = 1'b1;
            sel_word  = WORD_IDX_W'(w);
         end
      end
   end

   assign span     = ADDR_W'(eff_total) << page_shift_ff;
   assign low_mask = (ADDR_W'(1) << page_shift_ff) - ADDR_W'(1);
   assign page_of  = PAGE_IDX_W'(addr_ff >> page_shift_ff);

   // valid pages of the selected word, filled from the top bit down
   assign first_page = TOTAL_W'({word_ff, BIT_IDX_W'(0)});
   assign remaining  = eff_total - first_page;
   assign valid_mask = (remaining >= TOTAL_W'(WORD_BITS)) ? '1
                       : ~({WORD_BITS{1'b1}} >> remaining[BIT_IDX_W-1:0]);
   assign avail      = ~rd_data_ff & valid_mask;

   always_comb begin
      lead_idx = '0;
      for (int b = 0; b < int'(WORD_BITS); b++) begin
         if (avail[b]) begin
            lead_idx = BIT_IDX_W'(int'(WORD_BITS) - 1 - b);
         end
      end
   end

   assign free_bit = WORD_BITS'(1) << (~page_ff[BIT_IDX_W-1:0]);
   assign shift_wr = csr_ch.data[SHIFT_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // register writes
   always_comb begin
      region_base_in = region_base_ff;
      page_total_in  = page_total_ff;
      page_shift_in  = page_shift_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_idx_type'(csr_ch.index))
            CSR_REGION_BASE: region_base_in = csr_ch.data;
            CSR_PAGE_TOTAL:  page_total_in  = csr_ch.data[TOTAL_W-1:0];
            CSR_PAGE_SHIFT: begin
               if (shift_wr < SHIFT_MIN) begin
                  page_shift_in = SHIFT_MIN;
               end else if (shift_wr > SHIFT_MAX) begin
                  page_shift_in = SHIFT_MAX;
               end else begin
                  page_shift_in = shift_wr;
               end
            end
            default: ;
         endcase
      end
   end

   // command sequencer
   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      full_in       = full_ff;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      below_in      = below_ff;
      word_in       = word_ff;
      page_in       = page_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_waddr     = word_ff;
      mem_wdata     = '0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            clr_idx_in = clr_idx_ff + WORD_IDX_W'(1);
            if (clr_idx_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in        = cmd_type'(req_ch.command);
               addr_in       = req_ch.address;
               res_addr_in   = '0;
               res_status_in = STATUS_OK;
               state_in      = S_SELECT;
            end
         end
         S_SELECT: begin
            if (cmd_ff == CMD_ALLOC) begin
               if (sel_found) begin
                  word_in  = sel_word;
                  state_in = S_READ;
               end else begin
                  res_status_in = STATUS_NO_PAGES;
                  state_in      = S_OUT;
               end
            end else begin
               // keep the offset from the region base in addr_ff
               addr_in  = addr_ff - region_base_ff;
               below_in = addr_ff < region_base_ff;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (below_ff || (addr_ff >= span)) begin
               res_status_in = STATUS_RANGE;
               state_in      = S_OUT;
            end else if ((addr_ff & low_mask) != '0) begin
               res_status_in = STATUS_MISALIGNED;
               state_in      = S_OUT;
            end else begin
               page_in  = page_of;
               word_in  = WORD_IDX_W'(page_of >> BIT_IDX_W);
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_MODIFY;
         end
         S_MODIFY: begin
            if (cmd_ff == CMD_ALLOC) begin
               if (avail == '0) begin
                  res_status_in = STATUS_NO_PAGES;
                  state_in      = S_OUT;
               end else begin
                  mem_we           = 1'b1;
                  mem_wdata        = rd_data_ff | (WORD_BITS'(1) << (~lead_idx));
                  full_in[word_ff] = &mem_wdata;
                  page_in          = PAGE_IDX_W'({word_ff, lead_idx});
                  state_in         = S_ADDR;
               end
            end else begin
               if ((rd_data_ff & free_bit) == '0) begin
                  res_status_in = STATUS_ALREADY_FREE;
               end else begin
                  mem_we           = 1'b1;
                  mem_wdata        = rd_data_ff & ~free_bit;
                  full_in[word_ff] = 1'b0;
                  res_status_in    = STATUS_OK;
               end
               state_in = S_OUT;
            end
         end
         S_ADDR: begin
            res_addr_in   = region_base_ff + (ADDR_W'(page_ff) << page_shift_ff);
            res_status_in = STATUS_OK;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_idx_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         full_ff        <= '0;
         region_base_ff <= '0;
         page_total_ff  <= '0;
         page_shift_ff  <= SHIFT_RESET;
      end else begin
         state_ff       <= state_in;
         clr_idx_ff     <= clr_idx_in;
         rsp_valid_ff   <= rsp_valid_in;
         full_ff        <= full_in;
         region_base_ff <= region_base_in;
         page_total_ff  <= page_total_in;
         page_shift_ff  <= page_shift_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      below_ff      <= below_in;
      word_ff       <= word_in;
      page_ff       <= page_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   // bitmap word memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         used_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= used_mem[word_ff];
   end

   `BPA_ASSERT_SAME(a_sel_not_full,
      (state_ff == S_SELECT) && (cmd_ff == CMD_ALLOC) && sel_found,
      !full_ff[sel_word],
      "allocate selected a word marked full")

   `BPA_ASSERT_SAME(a_alloc_sets_one,
      (state_ff == S_MODIFY) && mem_we && (cmd_ff == CMD_ALLOC),
      $countones(mem_wdata) == $countones(rd_data_ff) + 1,
      "allocate write-back does not set exactly one bit")

   `BPA_ASSERT_SAME(a_free_clears_one,
      (state_ff == S_MODIFY) && mem_we && (cmd_ff == CMD_FREE),
      $countones(mem_wdata) + 1 == $countones(rd_data_ff),
      "free write-back does not clear exactly one bit")

   `BPA_ASSERT_NEXT(a_one_in_flight,
      req_ch.valid && req_ch.ready,
      !req_ch.ready,
      "second transaction taken while one is in flight")

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap page allocator. Commands go out from a
// queue with random gaps, results come back under random stalls. Each
// accepted command is run through a local bitmap model, and every result is
// checked field by field against the model. The region registers are
// reprogrammed between phases, with clamped and wrapping settings included.
// ----------------------------------------------------------------------------
module tb_top;
   import bpa_pkg::*;

   localparam int unsigned MAP_WORDS     = DEFAULT_MAX_PAGES / WORD_BITS;
   localparam int unsigned RESET_CYCLES  = 12;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned MAX_REPORTS   = 10;
   // no register decodes at this index
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      cmd_type             command;
      logic [ADDR_W-1:0]   address;
   } page_command_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   page_address;
      status_type          status;
   } page_result_type;

   logic clock = 1'b0;
   logic reset;

   bpa_req_if req_ch();
   bpa_rsp_if rsp_ch();
   bpa_csr_if csr_ch();

   bitmap_page_allocator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #1 clock = ~clock;

   // local copy of the allocator state
   logic [WORD_BITS-1:0] used_map [MAP_WORDS];
   logic [ADDR_W-1:0]    cfg_base;
   logic [TOTAL_W-1:0]   cfg_total;
   logic [SHIFT_W-1:0]   cfg_shift;

   page_command_type queued_commands [$];
   page_result_type  awaited_results [$];

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned hold_request;
   int unsigned hold_left;
   bit          req_fire;
   bit          csr_fire;
   int unsigned mismatches;
   int unsigned results_seen;
   int unsigned commands_taken;
   int unsigned reg_writes;
   int unsigned cycle_count;
   int unsigned status_tally [8];

   function automatic int unsigned usable_pages();
      return (cfg_total > DEFAULT_MAX_PAGES) ? DEFAULT_MAX_PAGES : cfg_total;
   endfunction

   // applies one command to the local bitmap and returns its result
   function automatic page_result_type page_outcome(page_command_type cmd);
      page_result_type      res;
      int unsigned          pages;
      int unsigned          first;
      int unsigned          page_pos;
      int unsigned          word_idx;
      int unsigned          bit_pos;
      logic [WORD_BITS-1:0] avail;
      logic [ADDR_W-1:0]    page_num;
      logic [ADDR_W-1:0]    span;
      logic [ADDR_W-1:0]    offset;
      bit                   found;
      pages = usable_pages();
      res.page_address = '0;
      res.status = STATUS_NO_PAGES;
      found = 1'b0;
      if (cmd.command == CMD_ALLOC) begin
         for (int w = 0; w < MAP_WORDS; w++) begin
            first = w * WORD_BITS;
            if (!found && pages > first) begin
               if (pages - first >= WORD_BITS) begin
                  avail = '1;
               end else begin
                  avail = ~({WORD_BITS{1'b1}} >> (pages - first));
               end
               avail = avail & ~used_map[w];
               // words fill from the most significant end
               for (int b = WORD_BITS - 1; b >= 0; b--) begin
                  if (!found && avail[b]) begin
                     found = 1'b1;
                     used_map[w][b] = 1'b1;
                     page_num = first + (WORD_BITS - 1 - b);
                     res.page_address = cfg_base + (page_num << cfg_shift);
                     res.status = STATUS_OK;
                  end
               end
            end
         end
      end else begin
         page_num = pages;
         span = page_num << cfg_shift;
         offset = cmd.address - cfg_base;
         if (cmd.address < cfg_base || offset >= span) begin
            res.status = STATUS_RANGE;
         end else if ((offset & ((64'd1 << cfg_shift) - 64'd1)) != '0) begin
            res.status = STATUS_MISALIGNED;
         end else begin
            page_pos = offset >> cfg_shift;
            word_idx = page_pos / WORD_BITS;
            bit_pos = WORD_BITS - 1 - (page_pos % WORD_BITS);
            if (word_idx >= MAP_WORDS) begin
               res.status = STATUS_RANGE;
            end else if (!used_map[word_idx][bit_pos]) begin
               res.status = STATUS_ALREADY_FREE;
            end else begin
               used_map[word_idx][bit_pos] = 1'b0;
               res.status = STATUS_OK;
            end
         end
      end
      return res;
   endfunction

   // mostly pages inside the region, some just off it, some anywhere
   function automatic logic [ADDR_W-1:0] random_free_address();
      int unsigned       pages;
      int unsigned       pick;
      int unsigned       page_bytes;
      logic [ADDR_W-1:0] page_num;
      pages = usable_pages();
      pick = $urandom_range(99);
      page_bytes = 32'd1 << cfg_shift;
      page_num = (pages == 0) ? '0 : $urandom_range(pages - 1);
      if (pick < 70) return cfg_base + (page_num << cfg_shift);
      if (pick < 80) return cfg_base + (page_num << cfg_shift) + $urandom_range(page_bytes - 1, 1);
      if (pick < 88) begin
         page_num = pages + $urandom_range(3);
         return cfg_base + (page_num << cfg_shift);
      end
      if (pick < 94) return cfg_base - $urandom_range(4096, 1);
      return {$urandom, $urandom};
   endfunction

   task automatic queue_command(cmd_type command, logic [ADDR_W-1:0] address);
      page_command_type cmd;
      cmd.command = command;
      cmd.address = address;
      queued_commands.push_back(cmd);
   endtask

   task automatic random_commands(int unsigned count, int unsigned alloc_pct);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < alloc_pct) begin
            queue_command(CMD_ALLOC, {$urandom, $urandom});
         end else begin
            queue_command(CMD_FREE, random_free_address());
         end
      end
   endtask

   // checked at the rising edge, where the driver's last update has settled
   task automatic wait_idle();
      do @(posedge clock);
      while (queued_commands.size() != 0 || req_ch.valid || awaited_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [ADDR_W-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(negedge clock);
      while (!csr_fire);
      csr_ch.valid <= 1'b0;
   endtask

   // garbage above the field width must be dropped by the block
   task automatic configure(logic [ADDR_W-1:0] base, int unsigned pages, int unsigned shift);
      wait_idle();
      write_csr(CSR_REGION_BASE, base);
      write_csr(CSR_PAGE_TOTAL, ({$urandom, $urandom} << TOTAL_W) | pages);
      write_csr(CSR_PAGE_SHIFT, ({$urandom, $urandom} << SHIFT_W) | shift);
   endtask

   // command driver
   always @(negedge clock) begin
      page_command_type next_cmd;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (queued_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_cmd = queued_commands.pop_front();
            req_ch.valid   <= 1'b1;
            req_ch.command <= next_cmd.command;
            req_ch.address <= next_cmd.address;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result sink, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_left == 0 && hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: model update on each accepted transaction and result check
   always @(posedge clock) begin
      page_command_type    seen;
      page_result_type     want;
      logic [SHIFT_W-1:0]  shift_wr;
      req_fire = !reset && req_ch.valid && req_ch.ready;
      csr_fire = !reset && csr_ch.valid && csr_ch.ready;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result: address %h status %0d",
                           rsp_ch.page_address, rsp_ch.status);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_ch.page_address !== want.page_address || rsp_ch.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("result %0d: expected address %h status %0d, got address %h status %0d",
                              results_seen, want.page_address, want.status,
                              rsp_ch.page_address, rsp_ch.status);
               end
            end
         end
         if (csr_fire) begin
            reg_writes++;
            case (csr_ch.index)
               CSR_REGION_BASE: cfg_base = csr_ch.data;
               CSR_PAGE_TOTAL:  cfg_total = csr_ch.data[TOTAL_W-1:0];
               CSR_PAGE_SHIFT: begin
                  shift_wr = csr_ch.data[SHIFT_W-1:0];
                  if (shift_wr < SHIFT_MIN) shift_wr = SHIFT_MIN;
                  if (shift_wr > SHIFT_MAX) shift_wr = SHIFT_MAX;
                  cfg_shift = shift_wr;
               end
               default: ;
            endcase
         end
         if (req_fire) begin
            seen.command = cmd_type'(req_ch.command);
            seen.address = req_ch.address;
            want = page_outcome(seen);
            awaited_results.push_back(want);
            status_tally[want.status]++;
            commands_taken++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, awaited_results.size());
         $display("bitmap_page_allocator verification failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_ALLOC;
      req_ch.address = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_REGION_BASE;
      csr_ch.data = '0;
      for (int w = 0; w < MAP_WORDS; w++) used_map[w] = '0;
      for (int s = 0; s < 8; s++) status_tally[s] = 0;
      cfg_base = '0;
      cfg_total = '0;
      cfg_shift = SHIFT_RESET;
      send_idle_pct = 18;
      recv_idle_pct = 45;
      hold_request = 0;
      hold_left = 0;
      mismatches = 0;
      results_seen = 0;
      commands_taken = 0;
      reg_writes = 0;
      cycle_count = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values track no pages at all
      queue_command(CMD_ALLOC, '0);
      queue_command(CMD_FREE, '0);

      // three 8-byte pages, shift written below its minimum
      configure(64'h0000_0001_0000_0000, 3, 2);
      repeat (4) queue_command(CMD_ALLOC, {$urandom, $urandom});
      queue_command(CMD_FREE, cfg_base);
      queue_command(CMD_FREE, cfg_base);
      queue_command(CMD_FREE, cfg_base + 1);
      queue_command(CMD_FREE, cfg_base - 1);
      queue_command(CMD_FREE, cfg_base + 24);
      queue_command(CMD_FREE, '1);
      queue_command(CMD_FREE, cfg_base + 16);
      repeat (2) queue_command(CMD_ALLOC, '1);

      // a write to the unused index must leave the setup alone
      wait_idle();
      write_csr(CSR_SPARE, '1);
      queue_command(CMD_ALLOC, '0);
      queue_command(CMD_FREE, cfg_base);

      configure(64'h0000_0000_8000_0000, 100, 12);
      random_commands(220, 60);
      configure({$urandom, $urandom}, 200, 0);
      random_commands(220, 70);

      // count lowered below pages still marked used
      configure(cfg_base, 40, 3);
      random_commands(200, 50);
      hold_request = HOLD_CYCLES;

      configure(64'hFFFF_FFFF_FFFF_0000, 130, 10);
      send_idle_pct = 45;
      recv_idle_pct = 18;
      random_commands(200, 65);

      // count above the bound and shift above its maximum
      configure({32'h0000_0100, $urandom}, 8191, 31);
      queue_command(CMD_FREE, cfg_base + (64'd4095 << 30));
      queue_command(CMD_FREE, cfg_base + (64'd4096 << 30));
      queue_command(CMD_FREE, cfg_base + (64'd1 << 29));
      random_commands(200, 80);

      configure('0, 4096, 30);
      random_commands(200, 55);

      configure('1, 1, 5);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_commands(150, 50);
      configure({$urandom, $urandom}, 7, 20);
      random_commands(200, 55);

      wait_idle();
      $display("%0d commands: %0d ok, %0d out of pages, %0d out of range, %0d misaligned, %0d already free",
               commands_taken, status_tally[STATUS_OK], status_tally[STATUS_NO_PAGES],
               status_tally[STATUS_RANGE], status_tally[STATUS_MISALIGNED],
               status_tally[STATUS_ALREADY_FREE]);
      $display("%0d results checked over %0d register writes, %0d mismatches",
               results_seen, reg_writes, mismatches);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("bitmap_page_allocator verification clean");
      end else begin
         $display("bitmap_page_allocator verification failed");
      end
      $finish;
   end

endmodule
